// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int KIND_W         = 3;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NEG   = 3'd4,
    OP_RECIP = 3'd5,
    OP_CONJ  = 3'd6
  } op_t;

endpackage

// ===== hw/rtl/cau_ifs.sv =====
// ----------------------------------------------------------------------------
// cau_ifs
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface cau_in_if import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_re;
  logic signed [DATA_WIDTH-1:0] r_im;
  logic                         div_by_zero;
  logic                         overflow;

  modport source (output valid, r_re, r_im, div_by_zero, overflow, input ready);
  modport sink   (input valid, r_re, r_im, div_by_zero, overflow, output ready);
endinterface

// ===== hw/rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, sub, mul, div, negate, reciprocal and conjugate in signed
// fixed point with saturation and zero-divisor flag.
//
//   channel   dir  handshake      payload
//   in_port   in   valid/ready    kind, a_re, a_im, b_re, b_im
//   out_port  out  valid/ready    r_re, r_im, div_by_zero, overflow
//
// One word per cycle sustained while the output is not stalled. The divider
// resolves one quotient bit per stage.
// Reset clears all valid bits and queue pointers; no clearing pass.
// A stalled output freezes the execute pipeline; the input register and a
// 4-word queue keep taking words until both fill.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_port,
  cau_out_if.source out_port
);

  localparam int ITEM_W = 4 * DATA_WIDTH + KIND_W + 1;

  logic              push, full, pop, empty;
  logic [ITEM_W-1:0] f_item, q_item;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_port(in_port),
    .push   (push),
    .item   (f_item),
    .full   (full)
  );

  cau_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(f_item),
    .full (full),
    .pop  (pop),
    .rdata(q_item),
    .empty(empty)
  );

  cau_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .item    (q_item),
    .pop     (pop),
    .out_port(out_port)
  );

endmodule

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Input register: takes operand words, decodes the operation and flags a
// zero divisor before the word enters the queue.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ITEM_W     = 4 * DATA_WIDTH + KIND_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  cau_in_if.sink            in_port,
  output logic              push,
  output logic [ITEM_W-1:0] item,
  input  logic              full
);

  logic              f_v_r;
  logic [ITEM_W-1:0] item_r;
  logic [ITEM_W-1:0] item_nxt;
  op_t               op;
  logic              a_zero;
  logic              b_zero;
  logic              dz;

  assign push          = f_v_r & ~full;
  assign in_port.ready = ~f_v_r | ~full;
  assign item          = item_r;

  always_comb begin
    op       = op_t'(in_port.kind);
    a_zero   = (in_port.a_re == '0) && (in_port.a_im == '0);
    b_zero   = (in_port.b_re == '0) && (in_port.b_im == '0);
    dz       = ((op == OP_DIV) && b_zero) || ((op == OP_RECIP) && a_zero);
    item_nxt = {dz, in_port.kind, in_port.a_re, in_port.a_im, in_port.b_re, in_port.b_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_port.valid && in_port.ready) begin
      f_v_r <= 1'b1;
    end else if (push) begin
      f_v_r <= 1'b0;
    end
    if (in_port.valid && in_port.ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== hw/rtl/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// Short first-word-fall-through queue between decode and execute.
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   CAP  = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [AW:0]      count_r;

  assign full  = (count_r == CAP);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP)
    else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Execute pipeline: products, numerator and divisor setup, one quotient bit
// per stage for both parts, then saturation into the output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ITEM_W     = 4 * DATA_WIDTH + KIND_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  logic [ITEM_W-1:0] item,
  output logic              pop,
  cau_out_if.source         out_port
);

  localparam int DW   = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * DW;
  localparam int SW   = 2 * DW + 1;
  localparam int DENW = 2 * DW;
  localparam int NWD  = SW + F;
  localparam int NWR  = DW + 1 + 2 * F;
  localparam int NW   = (NWD > NWR) ? NWD : NWR;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW:0] sat_short(input logic signed [DW:0] v);
    logic o;
    o = v[DW] ^ v[DW-1];
    return {o, o ? (v[DW] ? MINV : MAXV) : v[DW-1:0]};
  endfunction

  function automatic logic [DW:0] sat_long(input logic signed [SW-1:0] v);
    logic o;
    o = ~((&v[SW-1:DW-1]) | ~(|v[SW-1:DW-1]));
    return {o, o ? (v[SW-1] ? MINV : MAXV) : v[DW-1:0]};
  endfunction

  logic en;

  // stage A
  logic                 a_v_r;
  op_t                  a_op_r;
  logic                 a_dz_r;
  logic [DW-1:0]        a_sre_r, a_sim_r;
  logic                 a_sovf_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_dr_r, p_di_r;
  logic signed [DW-1:0] a_are_r, a_aim_r;

  op_t                  i_op;
  logic                 i_dz;
  logic signed [DW-1:0] i_are, i_aim, i_bre, i_bim, x_re, x_im;
  logic signed [DW:0]   s_re, s_im;
  logic [DW:0]          st_re, st_im;

  // divider pipeline, index 0 is stage B
  logic            v_r     [0:NW];
  logic            isdiv_r [0:NW];
  logic            dz_r    [0:NW];
  logic [DW-1:0]   ere_r   [0:NW];
  logic [DW-1:0]   eim_r   [0:NW];
  logic            eovf_r  [0:NW];
  logic [DENW-1:0] den_r   [0:NW];
  logic [NW-1:0]   mre_r   [0:NW];
  logic [NW-1:0]   mim_r   [0:NW];
  logic            nre_r   [0:NW];
  logic            nim_r   [0:NW];
  logic [DENW-1:0] rre_r   [0:NW];
  logic [DENW-1:0] rim_r   [0:NW];
  logic [DW-1:0]   qre_r   [0:NW];
  logic [DW-1:0]   qim_r   [0:NW];
  logic            bre_r   [0:NW];
  logic            bim_r   [0:NW];

  logic signed [SW-1:0] m_re, m_im;
  logic [DW:0]          mt_re, mt_im;
  logic signed [SW-1:0] d_sre, d_sim;
  logic signed [NW-1:0] n_re, n_im;
  logic [DW-1:0]        b_ere, b_eim;
  logic                 b_eovf;

  // output
  logic          out_v_r;
  logic [DW-1:0] out_re_r, out_im_r;
  logic          out_dz_r, out_ovf_r;
  logic          ov_re, ov_im;
  logic [DW-1:0] f_re, f_im;

  assign en  = ~out_v_r | out_port.ready;
  assign pop = en & ~empty;

  always_comb begin
    i_bim = item[DW-1:0];
    i_bre = item[2*DW-1:DW];
    i_aim = item[3*DW-1:2*DW];
    i_are = item[4*DW-1:3*DW];
    i_op  = op_t'(item[4*DW+KIND_W-1:4*DW]);
    i_dz  = item[4*DW+KIND_W];
    x_re  = (i_op == OP_RECIP) ? i_are : i_bre;
    x_im  = (i_op == OP_RECIP) ? i_aim : i_bim;
    unique case (i_op)
      OP_ADD: begin
        s_re = i_are + i_bre;
        s_im = i_aim + i_bim;
      end
      OP_SUB: begin
        s_re = i_are - i_bre;
        s_im = i_aim - i_bim;
      end
      OP_NEG: begin
        s_re = -i_are;
        s_im = -i_aim;
      end
      OP_CONJ: begin
        s_re = i_are;
        s_im = -i_aim;
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    st_re = sat_short(s_re);
    st_im = sat_short(s_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= pop;
    end
    if (en) begin
      a_op_r   <= i_op;
      a_dz_r   <= i_dz;
      a_sre_r  <= st_re[DW-1:0];
      a_sim_r  <= st_im[DW-1:0];
      a_sovf_r <= st_re[DW] | st_im[DW];
      p_rr_r   <= i_are * i_bre;
      p_ii_r   <= i_aim * i_bim;
      p_ri_r   <= i_are * i_bim;
      p_ir_r   <= i_aim * i_bre;
      p_dr_r   <= x_re * x_re;
      p_di_r   <= x_im * x_im;
      a_are_r  <= i_are;
      a_aim_r  <= i_aim;
    end
  end

  // stage B: multiply result, divisor, numerator magnitudes
  always_comb begin
    m_re  = (SW'(p_rr_r) - SW'(p_ii_r)) >>> F;
    m_im  = (SW'(p_ri_r) + SW'(p_ir_r)) >>> F;
    mt_re = sat_long(m_re);
    mt_im = sat_long(m_im);
    d_sre = SW'(p_rr_r) + SW'(p_ii_r);
    d_sim = SW'(p_ir_r) - SW'(p_ri_r);
    if (a_op_r == OP_RECIP) begin
      n_re = NW'(a_are_r) <<< (2 * F);
      n_im = (-NW'(a_aim_r)) <<< (2 * F);
    end else begin
      n_re = NW'(d_sre) <<< F;
      n_im = NW'(d_sim) <<< F;
    end
    if (a_op_r == OP_MUL) begin
      b_ere  = mt_re[DW-1:0];
      b_eim  = mt_im[DW-1:0];
      b_eovf = mt_re[DW] | mt_im[DW];
    end else begin
      b_ere  = a_sre_r;
      b_eim  = a_sim_r;
      b_eovf = a_sovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= a_v_r;
    end
    if (en) begin
      isdiv_r[0] <= ((a_op_r == OP_DIV) || (a_op_r == OP_RECIP)) && !a_dz_r;
      dz_r[0]    <= a_dz_r;
      ere_r[0]   <= b_ere;
      eim_r[0]   <= b_eim;
      eovf_r[0]  <= b_eovf;
      den_r[0]   <= DENW'(p_dr_r) + DENW'(p_di_r);
      nre_r[0]   <= n_re[NW-1];
      nim_r[0]   <= n_im[NW-1];
      mre_r[0]   <= n_re[NW-1] ? NW'(-n_re) : NW'(n_re);
      mim_r[0]   <= n_im[NW-1] ? NW'(-n_im) : NW'(n_im);
      rre_r[0]   <= '0;
      rim_r[0]   <= '0;
      qre_r[0]   <= '0;
      qim_r[0]   <= '0;
      bre_r[0]   <= 1'b0;
      bim_r[0]   <= 1'b0;
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_div
    localparam int K = NW - i;
    logic [DENW:0] sh_re, sh_im, df_re, df_im;
    logic          ge_re, ge_im;

    always_comb begin
      sh_re = {rre_r[i-1], mre_r[i-1][K]};
      sh_im = {rim_r[i-1], mim_r[i-1][K]};
      df_re = sh_re - {1'b0, den_r[i-1]};
      df_im = sh_im - {1'b0, den_r[i-1]};
      ge_re = ~df_re[DENW];
      ge_im = ~df_im[DENW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
      if (en) begin
        isdiv_r[i] <= isdiv_r[i-1];
        dz_r[i]    <= dz_r[i-1];
        ere_r[i]   <= ere_r[i-1];
        eim_r[i]   <= eim_r[i-1];
        eovf_r[i]  <= eovf_r[i-1];
        den_r[i]   <= den_r[i-1];
        mre_r[i]   <= mre_r[i-1];
        mim_r[i]   <= mim_r[i-1];
        nre_r[i]   <= nre_r[i-1];
        nim_r[i]   <= nim_r[i-1];
        rre_r[i]   <= ge_re ? df_re[DENW-1:0] : sh_re[DENW-1:0];
        rim_r[i]   <= ge_im ? df_im[DENW-1:0] : sh_im[DENW-1:0];
        qre_r[i]   <= {qre_r[i-1][DW-2:0], ge_re};
        qim_r[i]   <= {qim_r[i-1][DW-2:0], ge_im};
        bre_r[i]   <= bre_r[i-1] | qre_r[i-1][DW-1];
        bim_r[i]   <= bim_r[i-1] | qim_r[i-1][DW-1];
      end
    end
  end

  // quotient saturation
  always_comb begin
    if (nre_r[NW]) begin
      ov_re = bre_r[NW] | (qre_r[NW][DW-1] & (|qre_r[NW][DW-2:0]));
      f_re  = ov_re ? MINV : -qre_r[NW];
    end else begin
      ov_re = bre_r[NW] | qre_r[NW][DW-1];
      f_re  = ov_re ? MAXV : qre_r[NW];
    end
    if (nim_r[NW]) begin
      ov_im = bim_r[NW] | (qim_r[NW][DW-1] & (|qim_r[NW][DW-2:0]));
      f_im  = ov_im ? MINV : -qim_r[NW];
    end else begin
      ov_im = bim_r[NW] | qim_r[NW][DW-1];
      f_im  = ov_im ? MAXV : qim_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[NW];
    end
    if (en) begin
      out_dz_r <= dz_r[NW];
      if (isdiv_r[NW]) begin
        out_re_r  <= f_re;
        out_im_r  <= f_im;
        out_ovf_r <= ov_re | ov_im;
      end else begin
        out_re_r  <= ere_r[NW];
        out_im_r  <= eim_r[NW];
        out_ovf_r <= eovf_r[NW];
      end
    end
  end

  assign out_port.valid       = out_v_r;
  assign out_port.r_re        = out_re_r;
  assign out_port.r_im        = out_im_r;
  assign out_port.div_by_zero = out_dz_r;
  assign out_port.overflow    = out_ovf_r;

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_dz_r |-> !out_ovf_r && out_re_r == '0 && out_im_r == '0)
    else $error("zero divisor word carries data or overflow");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r[NW]) && $stable(v_r[0]))
    else $error("pipeline moved while stalled");
  a_dz_not_div: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && dz_r[0] |-> !isdiv_r[0])
    else $error("zero divisor sent to divider");

endmodule
